/* rtl/trsd_pkg.sv */
// ----------------------------------------------------------------------------
// Text record stream decoder package
// Shared widths, character codes and the command passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package trsd_pkg;

  localparam int BYTE_W              = 8;
  localparam int NUM_W               = 15;
  localparam int POS_W               = 3;
  localparam int HEADER_BYTES_DEFAULT = 28;
  localparam int QUEUE_DEPTH_DEFAULT  = 4;

  localparam logic [NUM_W-1:0]  END_NUMBER   = NUM_W'(10999);
  localparam logic [NUM_W-1:0]  FIVE_DIGITS  = NUM_W'(10000);

  localparam logic [BYTE_W-1:0] CHAR_NL      = 8'h0a;
  localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_COLON   = 8'h3a;
  localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;

  typedef struct packed {
    logic              has_prefix;
    logic [NUM_W-1:0]  num;
    logic              has_text;
    logic [BYTE_W-1:0] text;
    logic              has_nl;
  } trsd_cmd_t;

endpackage

`default_nettype wire

/* rtl/trsd_front.sv */
// ----------------------------------------------------------------------------
// Record parser
// Accepts input bytes, tracks the record phase and queues output commands.
// ----------------------------------------------------------------------------
`default_nettype none

module trsd_front
  import trsd_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic              cfg_data,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              end_of_stream,
  input  wire logic              queue_full,
  output      logic              push,
  output      trsd_cmd_t         cmd
);

  typedef enum logic [5:0] {
    PH_SKIP = 6'b000001,
    PH_LOW  = 6'b000010,
    PH_HIGH = 6'b000100,
    PH_LEN  = 6'b001000,
    PH_BODY = 6'b010000,
    PH_STOP = 6'b100000
  } phase_t;

  phase_t            phase, phase_next, eff_phase;
  logic [BYTE_W-1:0] skip_count, skip_count_next;
  logic [BYTE_W-1:0] number_low_byte, number_low_byte_next;
  logic [BYTE_W-1:0] number_high_byte, number_high_byte_next;
  logic [BYTE_W-1:0] bytes_left, bytes_left_next;
  logic              number_lines;
  logic              accept;
  logic [NUM_W-1:0]  num;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  assign num = NUM_W'(number_high_byte[7:4]) * NUM_W'(1000)
             + NUM_W'(number_high_byte[3:0]) * NUM_W'(100)
             + NUM_W'(number_low_byte[7:4])  * NUM_W'(10)
             + NUM_W'(number_low_byte[3:0]);

  always_comb begin
    if (phase == PH_SKIP && skip_count >= BYTE_W'(HEADER_BYTES)) begin
      eff_phase = PH_LOW;
    end else begin
      eff_phase = phase;
    end
  end

  always_comb begin
    phase_next            = phase;
    skip_count_next       = skip_count;
    number_low_byte_next  = number_low_byte;
    number_high_byte_next = number_high_byte;
    bytes_left_next       = bytes_left;
    push                  = 1'b0;
    cmd                   = '0;
    if (accept) begin
      if (end_of_stream) begin
        if (phase == PH_BODY) begin
          push       = 1'b1;
          cmd.has_nl = 1'b1;
        end
        phase_next = PH_STOP;
      end else begin
        unique case (eff_phase)
          PH_SKIP: begin
            skip_count_next = skip_count + BYTE_W'(1);
            if (skip_count_next >= BYTE_W'(HEADER_BYTES)) begin
              phase_next = PH_LOW;
            end
          end
          PH_LOW: begin
            number_low_byte_next = in_byte;
            phase_next           = PH_HIGH;
          end
          PH_HIGH: begin
            number_high_byte_next = in_byte;
            phase_next            = PH_LEN;
          end
          PH_LEN: begin
            if (num == END_NUMBER) begin
              phase_next = PH_STOP;
            end else begin
              push           = number_lines || (in_byte == '0);
              cmd.has_prefix = number_lines;
              cmd.num        = num;
              cmd.has_nl     = (in_byte == '0);
              bytes_left_next = in_byte;
              phase_next     = (in_byte == '0) ? PH_LOW : PH_BODY;
            end
          end
          PH_BODY: begin
            push            = 1'b1;
            cmd.has_text    = 1'b1;
            cmd.text        = in_byte;
            cmd.has_nl      = (bytes_left == BYTE_W'(1));
            bytes_left_next = bytes_left - BYTE_W'(1);
            if (bytes_left == BYTE_W'(1)) begin
              phase_next = PH_LOW;
            end
          end
          PH_STOP: begin
            phase_next = PH_STOP;
          end
          default: begin
            phase_next = PH_STOP;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SKIP;
      skip_count       <= '0;
      number_low_byte  <= '0;
      number_high_byte <= '0;
      bytes_left       <= '0;
      number_lines     <= 1'b0;
    end else begin
      phase            <= phase_next;
      skip_count       <= skip_count_next;
      number_low_byte  <= number_low_byte_next;
      number_high_byte <= number_high_byte_next;
      bytes_left       <= bytes_left_next;
      if (cfg_write) begin
        number_lines <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/trsd_queue.sv */
// ----------------------------------------------------------------------------
// Command queue
// Small first-in first-out buffer between the parser and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module trsd_queue
  import trsd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  trsd_cmd_t      push_cmd,
  input  wire logic      pop,
  output      logic      full,
  output      logic      head_valid,
  output      trsd_cmd_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  trsd_cmd_t       entries [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/trsd_back.sv */
// ----------------------------------------------------------------------------
// Output emitter
// Expands queued commands into output bytes, one byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module trsd_back
  import trsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  trsd_cmd_t              head,
  output      logic              pop,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [BYTE_W-1:0] out_byte,
  output      logic              last_of_burst
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIGIT = 7'b0000010,
    ST_SP1   = 7'b0000100,
    ST_COLON = 7'b0001000,
    ST_SP2   = 7'b0010000,
    ST_TEXT  = 7'b0100000,
    ST_NL    = 7'b1000000
  } step_t;

  localparam int WIDE_W = NUM_W + 2;

  function automatic logic [WIDE_W-1:0] pow10(input logic [POS_W-1:0] pos);
    logic [WIDE_W-1:0] p;
    case (pos)
      3'd0:    p = WIDE_W'(1);
      3'd1:    p = WIDE_W'(10);
      3'd2:    p = WIDE_W'(100);
      3'd3:    p = WIDE_W'(1000);
      3'd4:    p = WIDE_W'(10000);
      default: p = WIDE_W'(1);
    endcase
    return p;
  endfunction

  step_t             step, cur, first, tail, nxt;
  logic [NUM_W-1:0]  rem, cur_rem, rem_next;
  logic [POS_W-1:0]  pos, cur_pos;
  logic              lead, cur_lead, lead_next;
  logic [WIDE_W-1:0] p;
  logic [3:0]        d;
  logic [BYTE_W-1:0] byte_next;
  logic              load, adv, done;

  assign load = !out_valid || !out_stall;
  assign adv  = head_valid && load;

  always_comb begin
    first = head.has_prefix ? ST_DIGIT : (head.has_text ? ST_TEXT : ST_NL);
    tail  = head.has_text ? ST_TEXT : (head.has_nl ? ST_NL : ST_IDLE);
    if (step == ST_IDLE) begin
      cur      = first;
      cur_rem  = head.num;
      cur_pos  = (head.num >= FIVE_DIGITS) ? POS_W'(4) : POS_W'(3);
      cur_lead = 1'b1;
    end else begin
      cur      = step;
      cur_rem  = rem;
      cur_pos  = pos;
      cur_lead = lead;
    end
  end

  always_comb begin
    p = pow10(cur_pos);
    d = '0;
    for (int k = 1; k <= 9; k++) begin
      if (WIDE_W'(cur_rem) >= WIDE_W'(k) * p) begin
        d = 4'(k);
      end
    end
  end

  always_comb begin
    rem_next  = cur_rem;
    lead_next = cur_lead;
    byte_next = CHAR_NL;
    nxt       = ST_IDLE;
    unique case (cur)
      ST_DIGIT: begin
        if (cur_lead && d == '0 && cur_pos != '0) begin
          byte_next = CHAR_SPACE;
        end else begin
          byte_next = CHAR_ZERO + BYTE_W'(d);
        end
        lead_next = cur_lead && (d == '0);
        rem_next  = NUM_W'(WIDE_W'(cur_rem) - WIDE_W'(d) * p);
        nxt       = (cur_pos == '0) ? ST_SP1 : ST_DIGIT;
      end
      ST_SP1: begin
        byte_next = CHAR_SPACE;
        nxt       = ST_COLON;
      end
      ST_COLON: begin
        byte_next = CHAR_COLON;
        nxt       = ST_SP2;
      end
      ST_SP2: begin
        byte_next = CHAR_SPACE;
        nxt       = tail;
      end
      ST_TEXT: begin
        byte_next = head.text;
        nxt       = head.has_nl ? ST_NL : ST_IDLE;
      end
      ST_NL: begin
        byte_next = CHAR_NL;
        nxt       = ST_IDLE;
      end
      default: begin
        byte_next = CHAR_NL;
        nxt       = ST_IDLE;
      end
    endcase
  end

  assign done = (nxt == ST_IDLE);
  assign pop  = adv && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= ST_IDLE;
    end else begin
      if (load) begin
        out_valid <= head_valid;
      end
      if (adv) begin
        step <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte      <= byte_next;
      last_of_burst <= done;
      rem           <= rem_next;
      pos           <= cur_pos - POS_W'(1);
      lead          <= lead_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/text_record_stream_decoder.sv */
// ----------------------------------------------------------------------------
// Text record stream decoder
// Turns a byte stream of numbered line records into plain text.
// ----------------------------------------------------------------------------
// The input channel takes one file byte per transfer, or an end-of-stream
// marker. The output channel gives one text byte per transfer, and
// last_of_burst marks the final byte caused by one input transfer.
// The single register number_lines is written through cfg_write and cfg_data.
// A parser accepts input bytes and queues one command per byte that causes
// output. An emitter expands each command into its bytes, one per cycle
// while the output is not stalled. The first output byte is registered in
// the emitter's output register after its command has passed through the queue.
// Plain text bytes sustain one transfer per cycle while the output is not
// stalled; a length byte with numbering on expands into up to nine output
// bytes, and the input then stalls once the command queue is full.
// A stalled output holds its byte, while the parser keeps taking input until
// the queue fills. Reset clears the queue, the output valid flag and the
// parser state; the decoder then skips the file header again. After the end
// of the file, further input is taken and dropped until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module text_record_stream_decoder
  import trsd_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic              cfg_data,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              end_of_stream,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [BYTE_W-1:0] out_byte,
  output      logic              last_of_burst
);

  trsd_cmd_t push_cmd, head;
  logic      push, pop, full, head_valid;

  trsd_front #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .queue_full    (full),
    .push          (push),
    .cmd           (push_cmd)
  );

  trsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  trsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .last_of_burst (last_of_burst)
  );

endmodule

`default_nettype wire

/* rtl/trsd_checker.sv */
// ----------------------------------------------------------------------------
// Text record stream decoder checker
// Port-level assertions, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module trsd_checker
  import trsd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [BYTE_W-1:0] out_byte,
  input wire logic              last_of_burst
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Output valid dropped while stalled.");

  a_out_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_byte) && $stable(last_of_burst))
    else $error("Output payload changed while stalled.");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_reset_in: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("Input stalled right after reset.");

endmodule

bind text_record_stream_decoder trsd_checker u_trsd_checker (.*);

`default_nettype wire
